@@ hdl/pdta_pkg.sv @@
package pdta_pkg;

    // action codes
    typedef enum logic [1:0] {
        ACT_TIME     = 2'd0,
        ACT_DATE     = 2'd1,
        ACT_DATETIME = 2'd2
    } pdta_action_t;

    // widths of the conversion datapath
    localparam int VALUE_W    = 47;
    localparam int BIN_W      = 48;
    localparam int NUM_DIGITS = 14;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BITS_PER_STEP = 3;
    localparam int STEPS_SHORT   = 24 / BITS_PER_STEP;
    localparam int STEPS_LONG    = BIN_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(STEPS_LONG + 1);
    localparam int POS_W         = 5;

    // range limits
    localparam logic [VALUE_W-1:0] DATETIME_LIMIT = 47'd100000000000000;
    localparam logic [14:0]        YEAR_MAX       = 15'd9999;

    // default queue depth
    localparam int QUEUE_DEPTH = 2;

    // ascii codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [1:0]         action;
        logic [VALUE_W-1:0] packed_value;
    } pdta_in_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic       bad_value;
    } pdta_out_t;

    // one classified and converted value
    typedef struct packed {
        logic [1:0]       action;
        logic             bad;
        logic [BCD_W-1:0] digits;
        logic [3:0]       month_tens;
        logic [3:0]       month_units;
        logic [3:0]       day_tens;
        logic [3:0]       day_units;
    } pdta_entry_t;

    typedef struct packed {
        logic        valid;
        pdta_entry_t entry;
    } pdta_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pdta_qstat_t;

endpackage

@@ hdl/pdta_front.sv @@
module pdta_front
    import pdta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  pdta_in_t    item,
    input  pdta_qstat_t qstat,
    output pdta_push_t  push
);

    // one add-3 correction over all digits, then shift in one binary bit
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    // split a value below 32 into two decimal digits
    function automatic logic [7:0] small_bcd(input logic [4:0] v);
        logic [3:0] tens;
        logic [4:0] rest;
        if (v >= 5'd30) begin
            tens = 4'd3;
            rest = v - 5'd30;
        end
        else if (v >= 5'd20) begin
            tens = 4'd2;
            rest = v - 5'd20;
        end
        else if (v >= 5'd10) begin
            tens = 4'd1;
            rest = v - 5'd10;
        end
        else begin
            tens = 4'd0;
            rest = v;
        end
        return {tens, rest[3:0]};
    endfunction

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    pdta_entry_t      ent_reg, ent_next;

    logic             accept;
    logic             bad;
    logic [14:0]      year;
    logic [7:0]       month_bcd;
    logic [7:0]       day_bcd;
    logic [BIN_W-1:0] load_bin;
    logic [CNT_W-1:0] load_cnt;
    logic [BCD_W-1:0] s1, s2, s3;
    logic             done;
    pdta_entry_t      new_ent;

    assign item_stall = busy_reg || qstat.full;
    assign accept     = item_valid && !item_stall;
    assign done       = busy_reg && (cnt_reg == '0);

    // classify the incoming beat
    always_comb begin
        year      = item.packed_value[23:9];
        month_bcd = small_bcd({1'b0, item.packed_value[8:5]});
        day_bcd   = small_bcd(item.packed_value[4:0]);
        bad       = 1'b0;
        load_bin  = '0;
        load_cnt  = CNT_W'(STEPS_SHORT);
        case (item.action)
            ACT_TIME:
            begin
                bad      = item.packed_value[23];
                load_bin = {item.packed_value[23:0], 24'd0};
            end
            ACT_DATE:
            begin
                bad      = (year > YEAR_MAX);
                load_bin = {9'd0, year, 24'd0};
            end
            ACT_DATETIME:
            begin
                bad      = (item.packed_value >= DATETIME_LIMIT);
                load_bin = {1'b0, item.packed_value};
                load_cnt = CNT_W'(STEPS_LONG);
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
        new_ent             = '0;
        new_ent.action      = item.action;
        new_ent.bad         = bad;
        new_ent.month_tens  = month_bcd[7:4];
        new_ent.month_units = month_bcd[3:0];
        new_ent.day_tens    = day_bcd[7:4];
        new_ent.day_units   = day_bcd[3:0];
    end

    // three binary bits per cycle into the digit register
    always_comb begin
        s1 = dd_step(bcd_reg, bin_reg[BIN_W-1]);
        s2 = dd_step(s1, bin_reg[BIN_W-2]);
        s3 = dd_step(s2, bin_reg[BIN_W-3]);
    end

    // conversion control and push to the queue
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        ent_next  = ent_reg;
        push      = '0;
        if (accept) begin
            if (bad) begin
                push.valid = 1'b1;
                push.entry = new_ent;
            end
            else begin
                busy_next = 1'b1;
                cnt_next  = load_cnt;
                bin_next  = load_bin;
                bcd_next  = '0;
                ent_next  = new_ent;
            end
        end
        else if (busy_reg && (cnt_reg != '0)) begin
            cnt_next = cnt_reg - 1'b1;
            bin_next = {bin_reg[BIN_W-4:0], 3'b000};
            bcd_next = s3;
        end
        else if (done && !qstat.full) begin
            busy_next         = 1'b0;
            push.valid        = 1'b1;
            push.entry        = ent_reg;
            push.entry.digits = bcd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        ent_reg <= ent_next;
    end

    // the step counter only runs while a value is being converted
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (cnt_reg == '0))
        else $error("step counter running while front is idle");

endmodule

@@ hdl/pdta_queue.sv @@
module pdta_queue
    import pdta_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  pdta_push_t  push,
    input  logic        pop,
    output pdta_entry_t head,
    output pdta_qstat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pdta_entry_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = mem_reg[rd_ptr_reg];
    assign do_pop      = pop && !qstat.empty;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push.valid && qstat.full))
        else $error("push into a full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

@@ hdl/pdta_back.sv @@
module pdta_back
    import pdta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pdta_entry_t head,
    input  pdta_qstat_t qstat,
    output logic        pop,
    output logic        text_valid,
    input  logic        text_stall,
    output pdta_out_t   text
);

    function automatic logic [7:0] dchar(input logic [BCD_W-1:0] d, input int i);
        return CH_ZERO + {4'd0, d[4*i +: 4]};
    endfunction

    logic             valid_reg;
    pdta_out_t        out_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             load;
    logic [7:0]       ch;
    logic             is_last;
    logic [POS_W-1:0] idx;
    logic [BCD_W-1:0] dg;

    assign text_valid = valid_reg;
    assign text       = out_reg;
    assign load       = !qstat.empty && (!valid_reg || !text_stall);
    assign pop        = load && is_last;
    assign dg         = head.digits;

    // pick the character at the current position of the head entry
    always_comb begin
        ch      = CH_NUL;
        is_last = 1'b0;
        idx     = pos_reg;
        if (head.bad) begin
            is_last = 1'b1;
        end
        else begin
            case (head.action)
                ACT_TIME:
                begin
                    // a two-digit hour skips the leading hundreds place
                    idx     = pos_reg + ((dg[27:24] == 4'd0) ? 5'd1 : 5'd0);
                    is_last = (idx == 5'd8);
                    case (idx)
                        5'd0:    ch = dchar(dg, 6);
                        5'd1:    ch = dchar(dg, 5);
                        5'd2:    ch = dchar(dg, 4);
                        5'd3:    ch = CH_COLON;
                        5'd4:    ch = dchar(dg, 3);
                        5'd5:    ch = dchar(dg, 2);
                        5'd6:    ch = CH_COLON;
                        5'd7:    ch = dchar(dg, 1);
                        default: ch = dchar(dg, 0);
                    endcase
                end
                ACT_DATE:
                begin
                    is_last = (pos_reg == 5'd9);
                    case (pos_reg)
                        5'd0:    ch = dchar(dg, 3);
                        5'd1:    ch = dchar(dg, 2);
                        5'd2:    ch = dchar(dg, 1);
                        5'd3:    ch = dchar(dg, 0);
                        5'd4:    ch = CH_DASH;
                        5'd5:    ch = CH_ZERO + {4'd0, head.month_tens};
                        5'd6:    ch = CH_ZERO + {4'd0, head.month_units};
                        5'd7:    ch = CH_DASH;
                        5'd8:    ch = CH_ZERO + {4'd0, head.day_tens};
                        default: ch = CH_ZERO + {4'd0, head.day_units};
                    endcase
                end
                ACT_DATETIME:
                begin
                    is_last = (pos_reg == 5'd18);
                    case (pos_reg)
                        5'd0:    ch = dchar(dg, 13);
                        5'd1:    ch = dchar(dg, 12);
                        5'd2:    ch = dchar(dg, 11);
                        5'd3:    ch = dchar(dg, 10);
                        5'd4:    ch = CH_DASH;
                        5'd5:    ch = dchar(dg, 9);
                        5'd6:    ch = dchar(dg, 8);
                        5'd7:    ch = CH_DASH;
                        5'd8:    ch = dchar(dg, 7);
                        5'd9:    ch = dchar(dg, 6);
                        5'd10:   ch = CH_SPACE;
                        5'd11:   ch = dchar(dg, 5);
                        5'd12:   ch = dchar(dg, 4);
                        5'd13:   ch = CH_COLON;
                        5'd14:   ch = dchar(dg, 3);
                        5'd15:   ch = dchar(dg, 2);
                        5'd16:   ch = CH_COLON;
                        5'd17:   ch = dchar(dg, 1);
                        default: ch = dchar(dg, 0);
                    endcase
                end
                default:
                begin
                    is_last = 1'b1;
                end
            endcase
        end
    end

    // position within the current value
    always_comb begin
        pos_next = pos_reg;
        if (load) begin
            pos_next = is_last ? '0 : pos_reg + 1'b1;
        end
    end

    // output register and its valid
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else begin
            pos_reg <= pos_next;
            if (load) begin
                valid_reg <= 1'b1;
            end
            else if (!text_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            out_reg.character <= ch;
            out_reg.last      <= is_last;
            out_reg.bad_value <= head.bad;
        end
    end

    // a value part-way through printing keeps its queue entry
    a_pos_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != '0) |-> !qstat.empty)
        else $error("character position advanced with no entry at the head");

endmodule

@@ hdl/packed_date_time_to_ascii.sv @@
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+---------------------------------
// item     | in        | item_valid / item_stall | pdta_in_t  (action, packed_value)
// text     | out       | text_valid / text_stall | pdta_out_t (character, last, bad_value)
//
// the front takes a beat, then converts to decimal at three bits per cycle and queues the
// result once the queue has room; bad values queue in the accept cycle.
// the back sends one character per cycle while text_stall is low: 1 for a bad value, 8 or 9
// for time, 10 for date, 19 for datetime.
// reset clears control state only; no clearing pass is needed after reset.
// a stall on the text side fills the queue, after which item_stall rises.
module packed_date_time_to_ascii
    import pdta_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  pdta_in_t  item,
    output logic      text_valid,
    input  logic      text_stall,
    output pdta_out_t text
);

    pdta_push_t  push;
    pdta_qstat_t qstat;
    pdta_entry_t head;
    logic        pop;

    // classify and convert
    pdta_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .qstat      (qstat),
        .push       (push)
    );

    // decoupling queue
    pdta_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    // character generator
    pdta_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text)
    );

endmodule

@@ verif/tb_packed_date_time_to_ascii.sv @@
module tb_packed_date_time_to_ascii;

    import pdta_pkg::*;

    typedef logic [63:0] u64_t;

    // action code with no format behind it
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int DIRECTED_N     = 24;
    localparam int RANDOM_PER_RUN = 129;
    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 40;

    // how a directed row gets its expected text
    typedef enum logic [1:0] {
        CHK_TEXT,
        CHK_BAD,
        CHK_MODEL
    } check_kind_t;

    typedef struct {
        logic [1:0]         action;
        logic [VALUE_W-1:0] value;
        check_kind_t        check;
        string              text;
    } directed_row_t;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_stall;
    pdta_in_t  item       = '0;
    logic      text_valid;
    logic      text_stall = 1'b0;
    pdta_out_t text;

    pdta_out_t     expected_text [$];
    directed_row_t rows [DIRECTED_N];
    int            mismatch_count = 0;
    int            text_beats     = 0;
    int            quiet_cycles   = 0;
    int            send_idle_pct  = 38;
    int            take_idle_pct  = 68;
    int            send_idle [3]  = '{38, 68, 0};
    int            take_idle [3]  = '{68, 38, 0};

    packed_date_time_to_ascii dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text)
    );

    always #5 clk = ~clk;

    // expected character queue helpers
    task automatic push_char(input logic [7:0] ch);
        pdta_out_t c;
        c.character = ch;
        c.last      = 1'b0;
        c.bad_value = 1'b0;
        expected_text.push_back(c);
    endtask

    task automatic push_pair(input u64_t v);
        push_char(CH_ZERO + 8'((v / 10) % 10));
        push_char(CH_ZERO + 8'(v % 10));
    endtask

    task automatic push_quad(input u64_t v);
        push_pair((v / 100) % 100);
        push_pair(v % 100);
    endtask

    // flag the final character of the text just queued
    task automatic close_text();
        pdta_out_t c;
        c = expected_text.pop_back();
        c.last = 1'b1;
        expected_text.push_back(c);
    endtask

    task automatic push_bad();
        pdta_out_t c;
        c.character = CH_NUL;
        c.last      = 1'b1;
        c.bad_value = 1'b1;
        expected_text.push_back(c);
    endtask

    task automatic expect_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_char(s[i]);
        close_text();
    endtask

    // text that one packed value turns into
    task automatic render_value(input pdta_in_t it);
        u64_t v;
        u64_t t;
        u64_t hour;
        u64_t dpart;
        u64_t tpart;
        v = u64_t'(it.packed_value);
        t = v & 64'hFF_FFFF;
        if (it.action == ACT_TIME && !t[23])
        begin
            hour = t / 10000;
            if (hour >= 100)
                push_char(CH_ZERO + 8'(hour / 100));
            push_pair(hour % 100);
            push_char(CH_COLON);
            push_pair((t / 100) % 100);
            push_char(CH_COLON);
            push_pair(t % 100);
            close_text();
        end
        else if (it.action == ACT_DATE && (t >> 9) <= YEAR_MAX)
        begin
            push_quad(t >> 9);
            push_char(CH_DASH);
            push_pair((t >> 5) & 15);
            push_char(CH_DASH);
            push_pair(t & 31);
            close_text();
        end
        else if (it.action == ACT_DATETIME && v < DATETIME_LIMIT)
        begin
            dpart = v / 1000000;
            tpart = v % 1000000;
            push_quad(dpart / 10000);
            push_char(CH_DASH);
            push_pair((dpart / 100) % 100);
            push_char(CH_DASH);
            push_pair(dpart % 100);
            push_char(CH_SPACE);
            push_pair(tpart / 10000);
            push_char(CH_COLON);
            push_pair((tpart / 100) % 100);
            push_char(CH_COLON);
            push_pair(tpart % 100);
            close_text();
        end
        else
        begin
            push_bad();
        end
    endtask

    // random value: mostly well-formed fields, some raw noise
    function automatic pdta_in_t random_item();
        pdta_in_t    it;
        int unsigned pick;
        u64_t        raw;
        u64_t        y, mo, d, h, mi, s;
        pick = $urandom_range(0, 19);
        raw  = {$urandom, $urandom};
        it.packed_value = raw[VALUE_W-1:0];
        h  = u64_t'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 23)
                                                : $urandom_range(0, 99));
        mi = u64_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                : $urandom_range(0, 59));
        s  = u64_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                : $urandom_range(0, 59));
        y  = u64_t'(($urandom_range(0, 1) == 1) ? $urandom_range(1900, 2100)
                                                : $urandom_range(0, 9999));
        mo = u64_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(1, 12));
        d  = u64_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(1, 28));
        if (pick < 6)
        begin
            it.action = ACT_TIME;
            if (pick == 5)
                h = u64_t'($urandom_range(100, 838));
            if ($urandom_range(0, 4) != 0)
                it.packed_value[23:0] = 24'(h * 10000 + mi * 100 + s);
        end
        else if (pick < 12)
        begin
            it.action = ACT_DATE;
            if ($urandom_range(0, 4) != 0)
                it.packed_value[23:0] = {15'(y), 4'(mo), 5'(d)};
        end
        else if (pick < 19)
        begin
            it.action = ACT_DATETIME;
            if (pick == 18)
                it.packed_value = DATETIME_LIMIT - 47'(2) + 47'($urandom_range(0, 3));
            else if ($urandom_range(0, 4) != 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    d = u64_t'($urandom_range(0, 99));
                it.packed_value = 47'((((((y * 100 + mo) * 100 + d) * 100 + h) * 100 + mi)
                                       * 100) + s);
            end
        end
        else
        begin
            it.action = ACT_UNUSED;
        end
        return it;
    endfunction

    // offer one beat, with random idle cycles ahead of it
    task automatic send_item(input pdta_in_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("text beat %0d: %s got %0h expected %0h", text_beats, what, got, want);
        mismatch_count++;
    endtask

    // receiver back-pressure
    always @(posedge clk)
        text_stall <= ($urandom_range(0, 99) < take_idle_pct);

    // compare each text beat with the oldest expected character
    always @(posedge clk)
    begin : text_check
        pdta_out_t want;
        if (rst_n && text_valid && !text_stall)
        begin
            if (expected_text.size() == 0)
            begin
                report_mismatch("unexpected beat, character", 32'(text.character), 0);
            end
            else
            begin
                want = expected_text.pop_front();
                if (text.character !== want.character)
                    report_mismatch("character", 32'(text.character),
                                    32'(want.character));
                if (text.last !== want.last)
                    report_mismatch("last", 32'(text.last), 32'(want.last));
                if (text.bad_value !== want.bad_value)
                    report_mismatch("bad_value", 32'(text.bad_value),
                                    32'(want.bad_value));
            end
            text_beats++;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (text_valid && !text_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        pdta_in_t it;
        int       k;
        int       run;

        rows[0]  = '{ACT_TIME,     47'd0,                  CHK_TEXT,  "00:00:00"};
        rows[1]  = '{ACT_TIME,     47'd235959,             CHK_TEXT,  "23:59:59"};
        rows[2]  = '{ACT_TIME,     47'd999999,             CHK_TEXT,  "99:99:99"};
        rows[3]  = '{ACT_TIME,     47'd1000000,            CHK_TEXT,  "100:00:00"};
        rows[4]  = '{ACT_TIME,     47'h7F_FFFF,            CHK_TEXT,  "838:86:07"};
        rows[5]  = '{ACT_TIME,     47'h80_0000,            CHK_BAD,   ""};
        rows[6]  = '{ACT_TIME,     47'h7FFF_FFFF_FFFF,     CHK_BAD,   ""};
        rows[7]  = '{ACT_TIME,     {23'h7F_FFFF, 24'd123456}, CHK_TEXT, "12:34:56"};
        rows[8]  = '{ACT_TIME,     47'd5960,               CHK_MODEL, ""};
        rows[9]  = '{ACT_DATE,     47'd0,                  CHK_TEXT,  "0000-00-00"};
        rows[10] = '{ACT_DATE,     47'd5119903,            CHK_TEXT,  "9999-12-31"};
        rows[11] = '{ACT_DATE,     47'd5119999,            CHK_TEXT,  "9999-15-31"};
        rows[12] = '{ACT_DATE,     47'd5120000,            CHK_BAD,   ""};
        rows[13] = '{ACT_DATE,     47'hFF_FFFF,            CHK_BAD,   ""};
        rows[14] = '{ACT_DATE,     {23'h7F_FFFF, 24'd5119903}, CHK_TEXT, "9999-12-31"};
        rows[15] = '{ACT_DATE,     47'd1036381,            CHK_MODEL, ""};
        rows[16] = '{ACT_DATETIME, 47'd0,                  CHK_TEXT,  "0000-00-00 00:00:00"};
        rows[17] = '{ACT_DATETIME, 47'd99999999999999,     CHK_TEXT,  "9999-99-99 99:99:99"};
        rows[18] = '{ACT_DATETIME, 47'd100000000000000,    CHK_BAD,   ""};
        rows[19] = '{ACT_DATETIME, 47'h7FFF_FFFF_FFFF,     CHK_BAD,   ""};
        rows[20] = '{ACT_DATETIME, 47'd20240229235960,     CHK_MODEL, ""};
        rows[21] = '{ACT_DATETIME, 47'd19991231000000,     CHK_MODEL, ""};
        rows[22] = '{ACT_UNUSED,   47'd0,                  CHK_BAD,   ""};
        rows[23] = '{ACT_UNUSED,   47'h7FFF_FFFF_FFFF,     CHK_BAD,   ""};

        // hold reset low, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        for (k = 0; k < DIRECTED_N; k++)
        begin
            it.action       = rows[k].action;
            it.packed_value = rows[k].value;
            send_item(it);
            case (rows[k].check)
                CHK_TEXT: expect_text(rows[k].text);
                CHK_BAD:  push_bad();
                default:  render_value(it);
            endcase
        end

        // random values under three idle patterns
        for (run = 0; run < 3; run++)
        begin
            send_idle_pct = send_idle[run];
            take_idle_pct = take_idle[run];
            for (k = 0; k < RANDOM_PER_RUN; k++)
            begin
                it = random_item();
                send_item(it);
                render_value(it);
            end
        end
        item_valid <= 1'b0;

        // drain
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ packed_date_time_to_ascii.f @@
hdl/pdta_pkg.sv
hdl/pdta_front.sv
hdl/pdta_queue.sv
hdl/pdta_back.sv
hdl/packed_date_time_to_ascii.sv
verif/tb_packed_date_time_to_ascii.sv
